### hw/rtl/pcfc_pkg.sv
// ----------------------------------------------------------------------------
// pcfc_pkg
// shared types, codes and constant tables of the fov crop block
// ----------------------------------------------------------------------------
package pcfc_pkg;

    localparam int Q_W        = 16;   // quaternion component, q1.14
    localparam int ROT_W      = 16;   // rotation term, q1.14
    localparam int ANG_W      = 26;   // angle in 1/65536 degree, signed
    localparam int RANGE_W    = 23;
    localparam int ELEV_W     = 16;
    localparam int SPAN_W     = 17;
    localparam int IDX_W      = 6;
    localparam int CORDIC_MAX = 24;
    localparam int N_QPROD    = 10;
    localparam int N_ROT      = 9;
    localparam int N_SQ       = 5;
    localparam int QUO_W      = 15;   // quotient bits of one rotation term
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [RANGE_W-1:0]      MIN_RANGE_RST = 23'd102;
    localparam logic [RANGE_W-1:0]      MAX_RANGE_RST = 23'd40960;
    localparam logic [ELEV_W-1:0]       ELEV_MIN_RST  = 16'hF900;
    localparam logic [ELEV_W-1:0]       ELEV_MAX_RST  = 16'd13312;
    localparam logic [SPAN_W-1:0]       SPAN_RST      = 17'd92160;
    localparam logic [SPAN_W-1:0]       FULL_SPAN     = 17'd92160;
    localparam logic signed [ANG_W-1:0] HALF_TURN     = 26'sd11796480;
    localparam logic signed [ROT_W-1:0] Q14_ONE       = 16'sd16384;

    localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
        26'd2949120, 26'd1740967, 26'd919879, 26'd466945, 26'd234379, 26'd117304,
        26'd58666,   26'd29335,   26'd14668,  26'd7334,   26'd3667,   26'd1833,
        26'd917,     26'd458,     26'd229,    26'd115,    26'd57,     26'd29,
        26'd14,      26'd7,       26'd4,      26'd2,      26'd1,      26'd0
    };

    // quaternion products: ww xx yy zz xy wz xz wy yz wx
    localparam logic [1:0] QMUL_A [N_QPROD] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                                2'd0, 2'd1, 2'd0, 2'd2, 2'd0};
    localparam logic [1:0] QMUL_B [N_QPROD] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2,
                                                2'd3, 2'd3, 2'd2, 2'd3, 2'd1};

    // body product k: output lane k/3, world lane k%3, term at lane*3 + output
    localparam logic [3:0] BM_ROT [N_ROT] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4,
                                              4'd7, 4'd2, 4'd5, 4'd8};
    localparam logic [1:0] BM_ROW [N_ROT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
                                              2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] BM_COL [N_ROT] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
                                              2'd2, 2'd0, 2'd1, 2'd2};

    typedef enum logic [2:0] {
        REG_MIN_RANGE = 3'd0,
        REG_MAX_RANGE = 3'd1,
        REG_ELEV_MIN  = 3'd2,
        REG_ELEV_MAX  = 3'd3,
        REG_AZ_SPAN   = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_QMUL, S_NORM, S_TERM_INIT, S_DIV, S_TERM_STORE,
        S_POSE_FIN, S_DIFF, S_BMUL, S_BACC, S_BODY, S_SQ, S_RANGE, S_SQRT,
        S_ELEV_INIT, S_ELEV_STEP, S_ELEV_CHK, S_AZ_INIT, S_AZ_STEP, S_AZ_CHK,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_QMUL, OP_NORM, OP_TERM_INIT, OP_DIV_STEP,
        OP_TERM_STORE, OP_POSE_FIN, OP_DIFF, OP_BMUL, OP_BACC, OP_BODY, OP_SQ,
        OP_RANGE, OP_SQRT_STEP, OP_ELEV_INIT, OP_CORDIC_STEP, OP_ELEV_CHK,
        OP_AZ_INIT, OP_AZ_CHK, OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic item_is_point;
    } t_dp_status;

endpackage

### hw/rtl/pcfc_if.sv
// ----------------------------------------------------------------------------
// pcfc stream interfaces
// valid/ready channels for input items and result words
// ----------------------------------------------------------------------------
interface pcfc_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic signed [15:0]           quat_w;
    logic signed [15:0]           quat_x;
    logic signed [15:0]           quat_y;
    logic signed [15:0]           quat_z;
    logic                         frame_end;

    modport source (
        output valid, cmd, coord_x, coord_y, coord_z,
        output quat_w, quat_x, quat_y, quat_z, frame_end,
        input  ready
    );
    modport sink (
        input  valid, cmd, coord_x, coord_y, coord_z,
        input  quat_w, quat_x, quat_y, quat_z, frame_end,
        output ready
    );
endinterface

interface pcfc_out_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] body_x;
    logic signed [COORD_BITS-1:0] body_y;
    logic signed [COORD_BITS-1:0] body_z;
    logic                         kept;
    logic                         sweep_last;

    modport source (
        output valid, body_x, body_y, body_z, kept, sweep_last,
        input  ready
    );
    modport sink (
        input  valid, body_x, body_y, body_z, kept, sweep_last,
        output ready
    );
endinterface

### hw/rtl/point_cloud_fov_crop.sv
// ----------------------------------------------------------------------------
// point_cloud_fov_crop
// maps world points into the body frame and flags those inside the sensor fov
// ----------------------------------------------------------------------------
// usage
//   i_item: input words. cmd 0 is a pose (translation in coord_x..z,
//   quaternion in quat_w..z), cmd 1 is a world point with frame_end.
//   o_res: one result word per point (body point, kept, sweep_last);
//   poses give no result.
//   apb port: five limit registers at byte address 4*i, written in the
//   access phase, pready tied high; write them only while the block is idle.
// timing
//   one word at a time. the time a point takes from acceptance to result is
//   set by the shared multiplier, the bit-serial square root and the cordic
//   loop. the time a pose takes is set by the 15-step divider run for each
//   of the nine rotation terms.
// reset
//   identity pose, zero origin, no pose seen (kept reads 0 until the first
//   pose), limit registers to their defaults.
// stall
//   a finished result waits in the output register; the next word is still
//   accepted and worked on, and only its own result waits for the register.
// ----------------------------------------------------------------------------
module point_cloud_fov_crop #(
    parameter int COORD_BITS       = 24,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pcfc_in_if.sink                             i_item,
    pcfc_out_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcfc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pcfc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pcfc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import pcfc_pkg::*;

    // limit registers
    logic [RANGE_W-1:0]       r_min_range;
    logic [RANGE_W-1:0]       r_max_range;
    logic signed [ELEV_W-1:0] r_elev_min;
    logic signed [ELEV_W-1:0] r_elev_max;
    logic [SPAN_W-1:0]        r_az_span;

    t_reg_idx   reg_sel;
    logic       cfg_wr;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= MIN_RANGE_RST;
            r_max_range <= MAX_RANGE_RST;
            r_elev_min  <= ELEV_MIN_RST;
            r_elev_max  <= ELEV_MAX_RST;
            r_az_span   <= SPAN_RST;
        end else if (cfg_wr) begin
            // addresses past the last register are ignored
            case (reg_sel)
                REG_MIN_RANGE: r_min_range <= pwdata[RANGE_W-1:0];
                REG_MAX_RANGE: r_max_range <= pwdata[RANGE_W-1:0];
                REG_ELEV_MIN:  r_elev_min  <= pwdata[ELEV_W-1:0];
                REG_ELEV_MAX:  r_elev_max  <= pwdata[ELEV_W-1:0];
                REG_AZ_SPAN:   r_az_span   <= pwdata[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_MIN_RANGE: prdata = CFG_DATA_W'(r_min_range);
            REG_MAX_RANGE: prdata = CFG_DATA_W'(r_max_range);
            REG_ELEV_MIN:  prdata = CFG_DATA_W'($unsigned(r_elev_min));
            REG_ELEV_MAX:  prdata = CFG_DATA_W'($unsigned(r_elev_max));
            REG_AZ_SPAN:   prdata = CFG_DATA_W'(r_az_span);
            default:       prdata = '0;
        endcase
    end

    // sequencer
    pcfc_ctrl #(
        .COORD_BITS       (COORD_BITS),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // arithmetic and the output word register
    pcfc_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_cmd_bit    (i_item.cmd),
        .i_coord_x    (i_item.coord_x),
        .i_coord_y    (i_item.coord_y),
        .i_coord_z    (i_item.coord_z),
        .i_quat_w     (i_item.quat_w),
        .i_quat_x     (i_item.quat_x),
        .i_quat_y     (i_item.quat_y),
        .i_quat_z     (i_item.quat_z),
        .i_frame_end  (i_item.frame_end),
        .i_min_range  (r_min_range),
        .i_max_range  (r_max_range),
        .i_elev_min   (r_elev_min),
        .i_elev_max   (r_elev_max),
        .i_az_span    (r_az_span),
        .o_body_x     (o_res.body_x),
        .o_body_y     (o_res.body_y),
        .o_body_z     (o_res.body_z),
        .o_kept       (o_res.kept),
        .o_sweep_last (o_res.sweep_last)
    );

endmodule

### hw/rtl/pcfc_ctrl.sv
// ----------------------------------------------------------------------------
// pcfc_ctrl
// sequencer: steps the datapath through pose and point work
// ----------------------------------------------------------------------------
module pcfc_ctrl #(
    parameter int COORD_BITS       = 24,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  pcfc_pkg::t_dp_status  i_status,
    output pcfc_pkg::t_dp_cmd     o_cmd
);
    import pcfc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_QMUL = IDX_W'(N_QPROD - 1);
    localparam logic [IDX_W-1:0] LAST_ROT  = IDX_W'(N_ROT - 1);
    localparam logic [IDX_W-1:0] LAST_SQ   = IDX_W'(N_SQ - 1);
    localparam logic [IDX_W-1:0] LAST_DIV  = IDX_W'(QUO_W - 1);
    localparam logic [IDX_W-1:0] LAST_SQRT = IDX_W'(COORD_BITS - 1);
    localparam logic [IDX_W-1:0] LAST_ANG  = IDX_W'(ANGLE_ITERATIONS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_sub, n_sub;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sub       <= n_sub;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_cnt   = '0;
                n_state = i_status.item_is_point ? S_DIFF : S_QMUL;
            end
            S_QMUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_QMUL) n_state = S_NORM;
            end
            S_NORM: begin
                n_cnt   = '0;
                n_state = S_TERM_INIT;
            end
            S_TERM_INIT: begin
                n_sub   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_sub = r_sub + 1'b1;
                if (r_sub == LAST_DIV) n_state = S_TERM_STORE;
            end
            S_TERM_STORE: begin
                n_cnt   = r_cnt + 1'b1;
                n_state = (r_cnt == LAST_ROT) ? S_POSE_FIN : S_TERM_INIT;
            end
            S_POSE_FIN: n_state = S_IDLE;
            S_DIFF: begin
                n_cnt   = '0;
                n_state = S_BMUL;
            end
            S_BMUL: n_state = S_BACC;
            S_BACC: begin
                n_cnt   = r_cnt + 1'b1;
                n_state = (r_cnt == LAST_ROT) ? S_BODY : S_BMUL;
            end
            S_BODY: begin
                n_cnt   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SQ) n_state = S_RANGE;
            end
            S_RANGE: begin
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SQRT) n_state = S_ELEV_INIT;
            end
            S_ELEV_INIT: begin
                n_cnt   = '0;
                n_state = S_ELEV_STEP;
            end
            S_ELEV_STEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_ANG) n_state = S_ELEV_CHK;
            end
            S_ELEV_CHK: n_state = S_AZ_INIT;
            S_AZ_INIT: begin
                n_cnt   = '0;
                n_state = S_AZ_STEP;
            end
            S_AZ_STEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_ANG) n_state = S_AZ_CHK;
            end
            S_AZ_CHK: n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op    = OP_NOP;
        o_cmd.idx   = r_cnt;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_QMUL:       o_cmd.op = OP_QMUL;
            S_NORM:       o_cmd.op = OP_NORM;
            S_TERM_INIT:  o_cmd.op = OP_TERM_INIT;
            S_DIV:        o_cmd.op = OP_DIV_STEP;
            S_TERM_STORE: o_cmd.op = OP_TERM_STORE;
            S_POSE_FIN:   o_cmd.op = OP_POSE_FIN;
            S_DIFF:       o_cmd.op = OP_DIFF;
            S_BMUL:       o_cmd.op = OP_BMUL;
            S_BACC:       o_cmd.op = OP_BACC;
            S_BODY:       o_cmd.op = OP_BODY;
            S_SQ:         o_cmd.op = OP_SQ;
            S_RANGE:      o_cmd.op = OP_RANGE;
            S_SQRT:       o_cmd.op = OP_SQRT_STEP;
            S_ELEV_INIT:  o_cmd.op = OP_ELEV_INIT;
            S_ELEV_STEP:  o_cmd.op = OP_CORDIC_STEP;
            S_ELEV_CHK:   o_cmd.op = OP_ELEV_CHK;
            S_AZ_INIT:    o_cmd.op = OP_AZ_INIT;
            S_AZ_STEP:    o_cmd.op = OP_CORDIC_STEP;
            S_AZ_CHK:     o_cmd.op = OP_AZ_CHK;
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd.op = OP_NOP;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/pcfc_dp.sv
// ----------------------------------------------------------------------------
// pcfc_dp
// datapath: shared multiplier, term divider, square root and cordic unit
// ----------------------------------------------------------------------------
module pcfc_dp #(
    parameter int COORD_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcfc_pkg::t_dp_cmd                  i_cmd,
    output pcfc_pkg::t_dp_status               o_status,
    input  logic                               i_cmd_bit,
    input  logic signed [COORD_BITS-1:0]       i_coord_x,
    input  logic signed [COORD_BITS-1:0]       i_coord_y,
    input  logic signed [COORD_BITS-1:0]       i_coord_z,
    input  logic signed [pcfc_pkg::Q_W-1:0]    i_quat_w,
    input  logic signed [pcfc_pkg::Q_W-1:0]    i_quat_x,
    input  logic signed [pcfc_pkg::Q_W-1:0]    i_quat_y,
    input  logic signed [pcfc_pkg::Q_W-1:0]    i_quat_z,
    input  logic                               i_frame_end,
    input  logic [pcfc_pkg::RANGE_W-1:0]       i_min_range,
    input  logic [pcfc_pkg::RANGE_W-1:0]       i_max_range,
    input  logic signed [pcfc_pkg::ELEV_W-1:0] i_elev_min,
    input  logic signed [pcfc_pkg::ELEV_W-1:0] i_elev_max,
    input  logic [pcfc_pkg::SPAN_W-1:0]        i_az_span,
    output logic signed [COORD_BITS-1:0]       o_body_x,
    output logic signed [COORD_BITS-1:0]       o_body_y,
    output logic signed [COORD_BITS-1:0]       o_body_z,
    output logic                               o_kept,
    output logic                               o_sweep_last
);
    import pcfc_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int MW  = (CB + 2 > 24) ? CB + 2 : 24;
    localparam int PW  = 2 * MW;
    localparam int SQW = 2 * MW - 2;
    localparam int SW  = CB + 18;
    localparam int CW  = CB + 3;
    localparam int RW  = CB + 3;
    localparam int HW  = 2 * CB;
    localparam int DW  = CB + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    // captured item
    logic                       r_cmd;
    logic signed [CB-1:0]       r_c [3];
    logic signed [Q_W-1:0]      r_q [4];
    logic                       r_fend;
    // pose state
    logic signed [ROT_W-1:0]    r_rot [N_ROT];
    logic signed [CB-1:0]       r_org [3];
    logic                       r_pose_valid;
    // pose scratch
    logic signed [31:0]         r_pq [N_QPROD];
    logic [32:0]                r_n2;
    logic [32:0]                r_rem;
    logic [QUO_W-1:0]           r_dvd;
    logic [QUO_W-1:0]           r_qt;
    logic                       r_neg;
    // point scratch
    logic signed [DW-1:0]       r_d [3];
    logic signed [SW-1:0]       r_prod;
    logic signed [SW-1:0]       r_acc [3];
    logic signed [CB-1:0]       r_b [3];
    logic [SQW-1:0]             r_sq [N_SQ];
    logic                       r_range_ok;
    logic [HW-1:0]              r_sv;
    logic [RW-1:0]              r_srem;
    logic [CB-1:0]              r_root;
    logic signed [CW-1:0]       r_cvx, r_cvy;
    logic signed [ANG_W-1:0]    r_ang;
    logic                       r_elev_ok;
    logic                       r_az_ok;

    logic [3:0]                 k4;
    logic [4:0]                 sh;
    logic signed [MW-1:0]       mul_a, mul_b;
    logic signed [PW-1:0]       mul_p;
    logic [MW-2:0]              sq_op;
    logic [CB-1:0]              ab [3];
    logic signed [35:0]         num;
    logic [32:0]                num_abs;
    logic [47:0]                dvd_full;
    logic [33:0]                div_t;
    logic                       div_ge;
    logic signed [ROT_W-1:0]    q_val;
    logic signed [CB-1:0]       sat_b [3];
    logic signed [SW-1:0]       rnd [3];
    logic [SQW-1:0]             horiz2, r2;
    logic [RW-1:0]              srem_t, trial;
    logic                       sqrt_ge;
    logic signed [CW-1:0]       xs, ys;
    logic signed [ANG_W-1:0]    elev, azim, elev_lo, elev_hi, az_lim;

    assign k4 = i_cmd.idx[3:0];
    assign sh = i_cmd.idx[4:0];
    assign o_status.item_is_point = r_cmd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ab[i] = r_b[i][CB-1] ? (~r_b[i] + 1'b1) : r_b[i];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sq_op = '0;
        case (i_cmd.op)
            OP_QMUL: begin
                mul_a = MW'(r_q[QMUL_A[k4]]);
                mul_b = MW'(r_q[QMUL_B[k4]]);
            end
            OP_BMUL: begin
                mul_a = MW'(r_rot[BM_ROT[k4]]);
                mul_b = MW'(r_d[BM_COL[k4]]);
            end
            OP_SQ: begin
                case (k4)
                    4'd0:    sq_op = (MW-1)'(ab[0]);
                    4'd1:    sq_op = (MW-1)'(ab[1]);
                    4'd2:    sq_op = (MW-1)'(ab[2]);
                    4'd3:    sq_op = (MW-1)'(i_min_range);
                    default: sq_op = (MW-1)'(i_max_range);
                endcase
                mul_a = $signed({1'b0, sq_op});
                mul_b = $signed({1'b0, sq_op});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // rotation term numerators, pq order ww xx yy zz xy wz xz wy yz wx
    always_comb begin
        case (k4)
            4'd0: num = 36'(r_pq[0]) + 36'(r_pq[1]) - 36'(r_pq[2]) - 36'(r_pq[3]);
            4'd1: num = (36'(r_pq[4]) - 36'(r_pq[5])) <<< 1;
            4'd2: num = (36'(r_pq[6]) + 36'(r_pq[7])) <<< 1;
            4'd3: num = (36'(r_pq[4]) + 36'(r_pq[5])) <<< 1;
            4'd4: num = 36'(r_pq[0]) - 36'(r_pq[1]) + 36'(r_pq[2]) - 36'(r_pq[3]);
            4'd5: num = (36'(r_pq[8]) - 36'(r_pq[9])) <<< 1;
            4'd6: num = (36'(r_pq[6]) - 36'(r_pq[7])) <<< 1;
            4'd7: num = (36'(r_pq[8]) + 36'(r_pq[9])) <<< 1;
            default: num = 36'(r_pq[0]) - 36'(r_pq[1]) - 36'(r_pq[2]) + 36'(r_pq[3]);
        endcase
        num_abs  = num[35] ? 33'(-num) : 33'(num);
        // quotient rounded half up: (|num| * 2^14 + n2/2) / n2
        dvd_full = {1'b0, num_abs, 14'b0} + 48'(r_n2 >> 1);
        div_t    = {r_rem, r_dvd[QUO_W-1]};
        div_ge   = div_t >= {1'b0, r_n2};
        q_val    = r_neg ? -$signed({1'b0, r_qt}) : $signed({1'b0, r_qt});
    end

    // round half away from zero, then clamp to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_acc[i] >= 0) begin
                rnd[i] = (r_acc[i] + SW'(8192)) >>> 14;
            end else begin
                rnd[i] = -((-r_acc[i] + SW'(8192)) >>> 14);
            end
            if (rnd[i] > SAT_HI) begin
                sat_b[i] = CB'(SAT_HI);
            end else if (rnd[i] < SAT_LO) begin
                sat_b[i] = CB'(SAT_LO);
            end else begin
                sat_b[i] = CB'(rnd[i]);
            end
        end
    end

    always_comb begin
        horiz2  = r_sq[0] + r_sq[1];
        r2      = horiz2 + r_sq[2];
        srem_t  = {r_srem[RW-3:0], r_sv[HW-1:HW-2]};
        trial   = RW'({r_root, 2'b01});
        sqrt_ge = srem_t >= trial;
        xs      = r_cvx >>> sh;
        ys      = r_cvy >>> sh;
        elev    = r_b[2][CB-1] ? -r_ang : r_ang;
        azim    = r_b[0][CB-1] ? HALF_TURN - r_ang : r_ang;
        elev_lo = ANG_W'(i_elev_min) <<< 8;
        elev_hi = ANG_W'(i_elev_max) <<< 8;
        az_lim  = $signed(ANG_W'({i_az_span, 7'b0}));
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_ROT; i++) begin
                r_rot[i] <= (i % 4 == 0) ? Q14_ONE : '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
            end
            r_pose_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_TERM_STORE) begin
                if (r_n2 == '0) begin
                    r_rot[k4] <= (k4 == 4'd0 || k4 == 4'd4 || k4 == 4'd8) ? Q14_ONE : '0;
                end else begin
                    r_rot[k4] <= q_val;
                end
            end
            if (i_cmd.op == OP_POSE_FIN) begin
                for (int i = 0; i < 3; i++) begin
                    r_org[i] <= r_c[i];
                end
                r_pose_valid <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd  <= i_cmd_bit;
                r_c[0] <= i_coord_x;
                r_c[1] <= i_coord_y;
                r_c[2] <= i_coord_z;
                r_q[0] <= i_quat_w;
                r_q[1] <= i_quat_x;
                r_q[2] <= i_quat_y;
                r_q[3] <= i_quat_z;
                r_fend <= i_frame_end;
            end
            OP_QMUL: r_pq[k4] <= 32'(mul_p);
            OP_NORM: begin
                r_n2 <= 33'($unsigned(r_pq[0])) + 33'($unsigned(r_pq[1]))
                      + 33'($unsigned(r_pq[2])) + 33'($unsigned(r_pq[3]));
            end
            OP_TERM_INIT: begin
                r_rem <= 33'(dvd_full >> QUO_W);
                r_dvd <= dvd_full[QUO_W-1:0];
                r_neg <= num[35];
                r_qt  <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? 33'(div_t - {1'b0, r_n2}) : 33'(div_t);
                r_dvd <= r_dvd << 1;
                r_qt  <= {r_qt[QUO_W-2:0], div_ge};
            end
            OP_DIFF: begin
                for (int j = 0; j < 3; j++) begin
                    r_d[j] <= DW'(r_c[j]) - DW'(r_org[j]);
                end
            end
            OP_BMUL: r_prod <= SW'(mul_p);
            OP_BACC: begin
                r_acc[BM_ROW[k4]] <= ((BM_COL[k4] == 2'd0) ? SW'(0) : r_acc[BM_ROW[k4]])
                                   + r_prod;
            end
            OP_BODY: begin
                for (int i = 0; i < 3; i++) begin
                    r_b[i] <= sat_b[i];
                end
            end
            OP_SQ: r_sq[k4[2:0]] <= SQW'(mul_p);
            OP_RANGE: begin
                r_range_ok <= !(r2 < r_sq[3] || r2 > r_sq[4]);
                r_sv       <= HW'(horiz2);
                r_srem     <= '0;
                r_root     <= '0;
            end
            OP_SQRT_STEP: begin
                r_srem <= sqrt_ge ? srem_t - trial : srem_t;
                r_root <= {r_root[CB-2:0], sqrt_ge};
                r_sv   <= r_sv << 2;
            end
            OP_ELEV_INIT: begin
                r_cvx <= $signed(CW'(r_root));
                r_cvy <= $signed(CW'(ab[2]));
                r_ang <= '0;
            end
            OP_AZ_INIT: begin
                r_cvx <= $signed(CW'(ab[0]));
                r_cvy <= $signed(CW'(ab[1]));
                r_ang <= '0;
            end
            OP_CORDIC_STEP: begin
                // no rotation once y has reached zero
                if (r_cvy > 0) begin
                    r_cvx <= r_cvx + ys;
                    r_cvy <= r_cvy - xs;
                    r_ang <= r_ang + $signed(ATAN_TAB[sh]);
                end else if (r_cvy < 0) begin
                    r_cvx <= r_cvx - ys;
                    r_cvy <= r_cvy + xs;
                    r_ang <= r_ang - $signed(ATAN_TAB[sh]);
                end
            end
            OP_ELEV_CHK: r_elev_ok <= !(elev < elev_lo || elev > elev_hi);
            OP_AZ_CHK:   r_az_ok   <= (i_az_span >= FULL_SPAN) || (azim <= az_lim);
            OP_OUT: begin
                o_body_x     <= r_b[0];
                o_body_y     <= r_b[1];
                o_body_z     <= r_b[2];
                o_kept       <= r_pose_valid && r_range_ok && r_elev_ok && r_az_ok;
                o_sweep_last <= r_fend;
            end
            default: begin
            end
        endcase
    end

endmodule
